/* design/blu_pkg.sv */
// Shared constants and types for the bilinear image upscaler.
package blu_pkg;

    localparam int SRC_WIDTH_DEF  = 256;
    localparam int SRC_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int PIXEL_W     = 8;
    localparam int LOAD_IDX_W  = 8;
    localparam int COORD_W     = 11;
    localparam int INV_SCALE_W = 15;

    localparam logic [INV_SCALE_W-1:0] INV_SCALE_RESET = 15'd4096;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

/* design/blu_if.sv */
// Channel interfaces for the bilinear image upscaler: items in, pixels out, scale writes.
interface blu_src_if;
    logic                              valid;
    logic                              ready;
    blu_pkg::func_t                    func;
    logic [blu_pkg::LOAD_IDX_W-1:0]    load_row;
    logic [blu_pkg::LOAD_IDX_W-1:0]    load_col;
    logic [blu_pkg::PIXEL_W-1:0]       load_pixel;
    logic [blu_pkg::COORD_W-1:0]       out_row;
    logic [blu_pkg::COORD_W-1:0]       out_col;

    modport source (
        output valid, func, load_row, load_col, load_pixel, out_row, out_col,
        input  ready
    );
    modport sink (
        input  valid, func, load_row, load_col, load_pixel, out_row, out_col,
        output ready
    );
endinterface

interface blu_dst_if;
    logic                          valid;
    logic                          ready;
    logic [blu_pkg::PIXEL_W-1:0]   pixel_out;

    modport source (
        output valid, pixel_out,
        input  ready
    );
    modport sink (
        input  valid, pixel_out,
        output ready
    );
endinterface

interface blu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [blu_pkg::INV_SCALE_W-1:0]   inv_scale;

    modport source (
        output valid, inv_scale,
        input  ready
    );
    modport sink (
        input  valid, inv_scale,
        output ready
    );
endinterface

/* design/blu_pixel_store.sv */
// Source image store in four banks split by row and column parity, one read of all four neighbours per beat.
module blu_pixel_store #(
    parameter int ROW_W = 8,
    parameter int COL_W = 8
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ROW_W-1:0]              rd_row0,
    input  logic [ROW_W-1:0]              rd_row1,
    input  logic [COL_W-1:0]              rd_col0,
    input  logic [COL_W-1:0]              rd_col1,
    input  logic                          wr_en,
    input  logic [ROW_W-1:0]              wr_row,
    input  logic [COL_W-1:0]              wr_col,
    input  logic [blu_pkg::PIXEL_W-1:0]   wr_pixel,
    output logic [blu_pkg::PIXEL_W-1:0]   p00,
    output logic [blu_pkg::PIXEL_W-1:0]   p01,
    output logic [blu_pkg::PIXEL_W-1:0]   p10,
    output logic [blu_pkg::PIXEL_W-1:0]   p11
);

    localparam int HALF_ROW_W = (ROW_W > 1) ? ROW_W - 1 : 1;
    localparam int HALF_COL_W = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int ADDR_W     = HALF_ROW_W + HALF_COL_W;
    localparam int BANK_DEPTH = 2 ** ADDR_W;

    logic [ROW_W-1:0]             row_sel [2];
    logic [COL_W-1:0]             col_sel [2];
    logic [ADDR_W-1:0]            wr_addr;
    logic [blu_pkg::PIXEL_W-1:0]  bank_q [4];
    logic                         r0_par_reg;
    logic                         r1_par_reg;
    logic                         c0_par_reg;
    logic                         c1_par_reg;

    // even-parity bank takes whichever neighbour index is even
    always_comb
    begin
        row_sel[0] = rd_row0[0] ? rd_row1 : rd_row0;
        row_sel[1] = rd_row0[0] ? rd_row0 : rd_row1;
        col_sel[0] = rd_col0[0] ? rd_col1 : rd_col0;
        col_sel[1] = rd_col0[0] ? rd_col0 : rd_col1;
        wr_addr    = {HALF_ROW_W'(wr_row >> 1), HALF_COL_W'(wr_col >> 1)};
    end

    for (genvar rp = 0; rp < 2; rp++)
    begin : g_row
        for (genvar cp = 0; cp < 2; cp++)
        begin : g_col
            logic [blu_pkg::PIXEL_W-1:0]  bank_mem [BANK_DEPTH];
            logic [blu_pkg::PIXEL_W-1:0]  q_reg;
            logic [ADDR_W-1:0]            rd_addr;

            assign rd_addr = {HALF_ROW_W'(row_sel[rp] >> 1), HALF_COL_W'(col_sel[cp] >> 1)};

            always_ff @(posedge clk)
            begin
                if (wr_en && (wr_row[0] == 1'(rp)) && (wr_col[0] == 1'(cp)))
                begin
                    bank_mem[wr_addr] <= wr_pixel;
                end
                if (rd_en)
                begin
                    q_reg <= bank_mem[rd_addr];
                end
            end

            assign bank_q[rp * 2 + cp] = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            r0_par_reg <= rd_row0[0];
            r1_par_reg <= rd_row1[0];
            c0_par_reg <= rd_col0[0];
            c1_par_reg <= rd_col1[0];
        end
    end

    assign p00 = bank_q[{r0_par_reg, c0_par_reg}];
    assign p01 = bank_q[{r0_par_reg, c1_par_reg}];
    assign p10 = bank_q[{r1_par_reg, c0_par_reg}];
    assign p11 = bank_q[{r1_par_reg, c1_par_reg}];

endmodule

/* design/bilinear_image_upscaler.sv */
// Top level of the bilinear image upscaler: seven-stage pipeline around a banked image store.
// The block takes one item per clock unless dst stalls, loads and queries mixed freely, and a
// query's pixel passes stages 1 to 6 and the output register on its way to dst. Loads write the
// source image in order with queries, so a query sees every load accepted before it; loads
// outside the image are dropped and give no output beat. The image sits in four banks by
// row and column parity, each with one read port, so all four neighbours of a position come
// out in a single cycle. A stall on dst backs up the pipeline stage by stage, and src stays
// ready while any stage is empty. The image holds no defined value after reset; read only
// pixels that were loaded. Write inv_scale only while no query is in flight.
module bilinear_image_upscaler #(
    parameter int SRC_WIDTH  = blu_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = blu_pkg::SRC_HEIGHT_DEF,
    parameter int FRAC_BITS  = blu_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    blu_cfg_if.sink     cfg,
    blu_src_if.sink     src,
    blu_dst_if.source   dst
);

    localparam int ROW_W = $clog2(SRC_HEIGHT);
    localparam int COL_W = $clog2(SRC_WIDTH);
    localparam int PW    = blu_pkg::COORD_W + blu_pkg::INV_SCALE_W;
    localparam int IPW   = PW - FRAC_BITS;
    localparam int WW    = FRAC_BITS + 1;
    localparam int HW    = blu_pkg::PIXEL_W + FRAC_BITS;
    localparam int MW    = blu_pkg::PIXEL_W + 2 * FRAC_BITS;
    localparam int SW    = MW + 1;

    localparam logic [WW-1:0]    ONE          = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IPW-1:0]   LAST_ROW_IP  = IPW'(SRC_HEIGHT - 1);
    localparam logic [IPW-1:0]   LAST_COL_IP  = IPW'(SRC_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(SRC_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL     = COL_W'(SRC_WIDTH - 1);

    logic [blu_pkg::INV_SCALE_W-1:0] inv_scale_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en_out;

    // stage 1: captured beat
    blu_pkg::func_t                   s1_func_reg;
    logic [blu_pkg::LOAD_IDX_W-1:0]   s1_load_row_reg;
    logic [blu_pkg::LOAD_IDX_W-1:0]   s1_load_col_reg;
    logic [blu_pkg::PIXEL_W-1:0]      s1_load_pixel_reg;
    logic [blu_pkg::COORD_W-1:0]      s1_out_row_reg;
    logic [blu_pkg::COORD_W-1:0]      s1_out_col_reg;

    // stage 2: scaled positions
    blu_pkg::func_t                   s2_func_reg;
    logic [PW-1:0]                    s2_pos_y_reg;
    logic [PW-1:0]                    s2_pos_x_reg;
    logic                             s2_wr_ok_reg;
    logic [ROW_W-1:0]                 s2_wr_row_reg;
    logic [COL_W-1:0]                 s2_wr_col_reg;
    logic [blu_pkg::PIXEL_W-1:0]      s2_wr_pixel_reg;
    logic [PW-1:0]                    s2_pos_y_next;
    logic [PW-1:0]                    s2_pos_x_next;
    logic                             s2_wr_ok_next;

    // stage 3: neighbour indices and fractions
    blu_pkg::func_t                   s3_func_reg;
    logic [ROW_W-1:0]                 s3_r0_reg;
    logic [ROW_W-1:0]                 s3_r1_reg;
    logic [COL_W-1:0]                 s3_c0_reg;
    logic [COL_W-1:0]                 s3_c1_reg;
    logic [FRAC_BITS-1:0]             s3_fy_reg;
    logic [FRAC_BITS-1:0]             s3_fx_reg;
    logic                             s3_wr_ok_reg;
    logic [ROW_W-1:0]                 s3_wr_row_reg;
    logic [COL_W-1:0]                 s3_wr_col_reg;
    logic [blu_pkg::PIXEL_W-1:0]      s3_wr_pixel_reg;
    logic [IPW-1:0]                   ip_y;
    logic [IPW-1:0]                   ip_x;
    logic [ROW_W-1:0]                 s3_r0_next;
    logic [ROW_W-1:0]                 s3_r1_next;
    logic [COL_W-1:0]                 s3_c0_next;
    logic [COL_W-1:0]                 s3_c1_next;

    // stage 4: neighbour pixels from the store
    logic [FRAC_BITS-1:0]             s4_fy_reg;
    logic [FRAC_BITS-1:0]             s4_fx_reg;
    logic [blu_pkg::PIXEL_W-1:0]      p00, p01, p10, p11;
    logic                             mem_rd_en;
    logic                             mem_wr_en;

    // stage 5: horizontal blend
    logic [FRAC_BITS-1:0]             s5_fy_reg;
    logic [HW-1:0]                    s5_h0_reg;
    logic [HW-1:0]                    s5_h1_reg;
    logic [WW-1:0]                    wx0, wx1;
    logic [HW-1:0]                    s5_h0_next;
    logic [HW-1:0]                    s5_h1_next;

    // stage 6: vertical products
    logic [MW-1:0]                    s6_m0_reg;
    logic [MW-1:0]                    s6_m1_reg;
    logic [WW-1:0]                    wy0, wy1;
    logic [MW-1:0]                    s6_m0_next;
    logic [MW-1:0]                    s6_m1_next;

    // output register
    logic [blu_pkg::PIXEL_W-1:0]      pixel_reg;
    logic [SW-1:0]                    sum;
    logic [blu_pkg::PIXEL_W-1:0]      pixel_next;

    assign en_out = !out_valid_reg || dst.ready;
    assign en6    = !v6_reg || en_out;
    assign en5    = !v5_reg || en6;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign src.ready     = en1;
    assign cfg.ready     = 1'b1;
    assign dst.valid     = out_valid_reg;
    assign dst.pixel_out = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg <= blu_pkg::INV_SCALE_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                inv_scale_reg <= cfg.inv_scale;
            end
            if (en1)
            begin
                v1_reg <= src.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            // drop loads at the store stage; in-range loads write the store there
            if (en4)
            begin
                v4_reg <= v3_reg && (s3_func_reg == blu_pkg::FUNC_QUERY);
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v6_reg;
            end
        end
    end

    always_comb
    begin
        s2_pos_y_next = PW'(s1_out_row_reg) * PW'(inv_scale_reg);
        s2_pos_x_next = PW'(s1_out_col_reg) * PW'(inv_scale_reg);
        s2_wr_ok_next = (32'(s1_load_row_reg) < SRC_HEIGHT) && (32'(s1_load_col_reg) < SRC_WIDTH);
    end

    // clamp to the last row and column past the edge
    always_comb
    begin
        ip_y = s2_pos_y_reg[PW-1:FRAC_BITS];
        ip_x = s2_pos_x_reg[PW-1:FRAC_BITS];
        if (ip_y >= LAST_ROW_IP)
        begin
            s3_r0_next = LAST_ROW;
            s3_r1_next = LAST_ROW;
        end
        else
        begin
            s3_r0_next = ROW_W'(ip_y);
            s3_r1_next = ROW_W'(ip_y) + ROW_W'(1);
        end
        if (ip_x >= LAST_COL_IP)
        begin
            s3_c0_next = LAST_COL;
            s3_c1_next = LAST_COL;
        end
        else
        begin
            s3_c0_next = COL_W'(ip_x);
            s3_c1_next = COL_W'(ip_x) + COL_W'(1);
        end
    end

    assign mem_rd_en = en4 && v3_reg && (s3_func_reg == blu_pkg::FUNC_QUERY);
    assign mem_wr_en = en4 && v3_reg && (s3_func_reg == blu_pkg::FUNC_LOAD) && s3_wr_ok_reg;

    always_comb
    begin
        wx1        = {1'b0, s4_fx_reg};
        wx0        = ONE - wx1;
        s5_h0_next = HW'(p00) * HW'(wx0) + HW'(p01) * HW'(wx1);
        s5_h1_next = HW'(p10) * HW'(wx0) + HW'(p11) * HW'(wx1);
        wy1        = {1'b0, s5_fy_reg};
        wy0        = ONE - wy1;
        s6_m0_next = MW'(s5_h0_reg) * MW'(wy0);
        s6_m1_next = MW'(s5_h1_reg) * MW'(wy1);
        sum        = SW'(s6_m0_reg) + SW'(s6_m1_reg);
        pixel_next = blu_pkg::PIXEL_W'(sum >> (2 * FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en1 && src.valid)
        begin
            s1_func_reg       <= src.func;
            s1_load_row_reg   <= src.load_row;
            s1_load_col_reg   <= src.load_col;
            s1_load_pixel_reg <= src.load_pixel;
            s1_out_row_reg    <= src.out_row;
            s1_out_col_reg    <= src.out_col;
        end
        if (en2 && v1_reg)
        begin
            s2_func_reg     <= s1_func_reg;
            s2_pos_y_reg    <= s2_pos_y_next;
            s2_pos_x_reg    <= s2_pos_x_next;
            s2_wr_ok_reg    <= s2_wr_ok_next;
            s2_wr_row_reg   <= ROW_W'(s1_load_row_reg);
            s2_wr_col_reg   <= COL_W'(s1_load_col_reg);
            s2_wr_pixel_reg <= s1_load_pixel_reg;
        end
        if (en3 && v2_reg)
        begin
            s3_func_reg     <= s2_func_reg;
            s3_r0_reg       <= s3_r0_next;
            s3_r1_reg       <= s3_r1_next;
            s3_c0_reg       <= s3_c0_next;
            s3_c1_reg       <= s3_c1_next;
            s3_fy_reg       <= s2_pos_y_reg[FRAC_BITS-1:0];
            s3_fx_reg       <= s2_pos_x_reg[FRAC_BITS-1:0];
            s3_wr_ok_reg    <= s2_wr_ok_reg;
            s3_wr_row_reg   <= s2_wr_row_reg;
            s3_wr_col_reg   <= s2_wr_col_reg;
            s3_wr_pixel_reg <= s2_wr_pixel_reg;
        end
        if (mem_rd_en)
        begin
            s4_fy_reg <= s3_fy_reg;
            s4_fx_reg <= s3_fx_reg;
        end
        if (en5 && v4_reg)
        begin
            s5_fy_reg <= s4_fy_reg;
            s5_h0_reg <= s5_h0_next;
            s5_h1_reg <= s5_h1_next;
        end
        if (en6 && v5_reg)
        begin
            s6_m0_reg <= s6_m0_next;
            s6_m1_reg <= s6_m1_next;
        end
        if (en_out && v6_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end

    blu_pixel_store #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_store (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_row0  (s3_r0_reg),
        .rd_row1  (s3_r1_reg),
        .rd_col0  (s3_c0_reg),
        .rd_col1  (s3_c1_reg),
        .wr_en    (mem_wr_en),
        .wr_row   (s3_wr_row_reg),
        .wr_col   (s3_wr_col_reg),
        .wr_pixel (s3_wr_pixel_reg),
        .p00      (p00),
        .p01      (p01),
        .p10      (p10),
        .p11      (p11)
    );

`ifndef NO_ASSERTIONS
    a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("store read and write in the same cycle");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !src.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg
                        && out_valid_reg && !dst.ready))
        else $error("src stalled with an empty stage");

    a_row_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (s3_func_reg == blu_pkg::FUNC_QUERY))
        |-> ((s3_r1_reg == s3_r0_reg) || (s3_r1_reg == s3_r0_reg + ROW_W'(1)))
            && (s3_r1_reg <= LAST_ROW))
        else $error("row neighbours out of range");

    a_col_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (s3_func_reg == blu_pkg::FUNC_QUERY))
        |-> ((s3_c1_reg == s3_c0_reg) || (s3_c1_reg == s3_c0_reg + COL_W'(1)))
            && (s3_c1_reg <= LAST_COL))
        else $error("column neighbours out of range");
`endif

endmodule

/* dv/blu_pixel_checker.sv */
`timescale 1ns / 100ps
// Pixel scoreboard for the bilinear image upscaler: mirrors image and scale, predicts and checks.
module blu_pixel_checker
    import blu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    blu_cfg_if   cfg,
    blu_src_if   src,
    blu_dst_if   dst,
    output int   mismatch_count,
    output int   pixels_owed
);

    localparam int IMG_W = SRC_WIDTH_DEF;
    localparam int IMG_H = SRC_HEIGHT_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam longint unsigned ONE = 64'd1 << FB;

    logic [PIXEL_W-1:0]     image_q [0:IMG_H-1][0:IMG_W-1];
    logic [INV_SCALE_W-1:0] scale_q;
    logic [PIXEL_W-1:0]     owed_q [$];
    logic [PIXEL_W-1:0]     want_px;
    int                     errs = 0;

    task automatic flag(input string what);
        $display("%0t mismatch: %s", $time, what);
        errs++;
    endtask

    function automatic void map_axis(
        input  logic [COORD_W-1:0] coord,
        input  int                 size,
        output int                 lo,
        output int                 hi,
        output longint unsigned    frac
    );
        longint unsigned pos;
        longint unsigned whole;
        pos   = 64'(coord) * 64'(scale_q);
        whole = pos >> FB;
        frac  = pos & (ONE - 1);
        if (whole >= size - 1)
        begin
            lo = size - 1;
            hi = size - 1;
        end
        else
        begin
            lo = int'(whole);
            hi = lo + 1;
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] interpolate(
        input logic [COORD_W-1:0] orow,
        input logic [COORD_W-1:0] ocol
    );
        int              r0;
        int              r1;
        int              c0;
        int              c1;
        longint unsigned fy;
        longint unsigned fx;
        longint unsigned acc;
        map_axis(orow, IMG_H, r0, r1, fy);
        map_axis(ocol, IMG_W, c0, c1, fx);
        acc = (ONE - fx) * (ONE - fy) * 64'(image_q[r0][c0])
            + fx * (ONE - fy) * 64'(image_q[r0][c1])
            + (ONE - fx) * fy * 64'(image_q[r1][c0])
            + fx * fy * 64'(image_q[r1][c1]);
        return PIXEL_W'(acc >> (2 * FB));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q <= INV_SCALE_RESET;
            owed_q.delete();
            pixels_owed    <= 0;
            mismatch_count <= errs;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                scale_q <= cfg.inv_scale;

            if (src.valid && src.ready)
            begin
                if (src.func == FUNC_LOAD)
                begin
                    if (src.load_row < IMG_H && src.load_col < IMG_W)
                        image_q[src.load_row][src.load_col] = src.load_pixel;
                end
                else
                    owed_q.push_back(interpolate(src.out_row, src.out_col));
            end

            if (dst.valid && dst.ready)
            begin
                if (owed_q.size() == 0)
                    flag($sformatf("pixel_out %0d with no query waiting", dst.pixel_out));
                else
                begin
                    want_px = owed_q.pop_front();
                    if (dst.pixel_out !== want_px)
                        flag($sformatf("pixel_out %0d, expected %0d", dst.pixel_out, want_px));
                end
            end

            pixels_owed    <= owed_q.size();
            mismatch_count <= errs;
        end
    end

endmodule

/* dv/bilinear_image_upscaler_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the bilinear image upscaler: clock, reset, beat generation and verdict.
module bilinear_image_upscaler_tb;
    import blu_pkg::*;

    localparam int IMG_W        = SRC_WIDTH_DEF;
    localparam int IMG_H        = SRC_HEIGHT_DEF;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int PHASE_BEATS  = 175;
    localparam int DRAIN_CYCLES = 12;

    logic                   clk;
    logic                   rst_n;
    logic                   calm;
    int                     mismatch_count;
    int                     pixels_owed;
    int                     beats_sent;
    logic [INV_SCALE_W-1:0] scale;
    bit                     loaded [0:IMG_H-1][0:IMG_W-1];

    blu_cfg_if cfg ();
    blu_src_if src ();
    blu_dst_if dst ();

    bilinear_image_upscaler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .src   (src),
        .dst   (dst)
    );

    blu_pixel_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .src            (src),
        .dst            (dst),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
        dst.ready <= calm || ($urandom_range(99) >= 6);

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int k;
        k = $urandom_range(9);
        if (k < 2)
            return '0;
        if (k == 2)
            return '1;
        return PIXEL_W'($urandom_range(255));
    endfunction

    function automatic int pick_coord(input int reach);
        case ($urandom_range(19))
            0:          return 0;
            1:          return COORD_MAX;
            2:          return reach;
            3, 4, 5, 6: return int'($urandom_range(COORD_MAX));
            default:    return int'($urandom_range(reach));
        endcase
    endfunction

    function automatic int source_index(input int coord, input int size);
        logic [31:0] pos;
        pos = 32'(coord) * 32'(scale);
        if ((pos >> FRAC_BITS_DEF) >= size - 1)
            return size - 1;
        return int'(pos >> FRAC_BITS_DEF);
    endfunction

    task automatic send_beat(
        input func_t                 f,
        input logic [LOAD_IDX_W-1:0] lrow,
        input logic [LOAD_IDX_W-1:0] lcol,
        input logic [PIXEL_W-1:0]    lpix,
        input logic [COORD_W-1:0]    orow,
        input logic [COORD_W-1:0]    ocol
    );
        logic took;
        while (!calm && $urandom_range(99) < 6)
        begin
            src.valid <= 1'b0;
            @(posedge clk);
        end
        src.valid      <= 1'b1;
        src.func       <= f;
        src.load_row   <= lrow;
        src.load_col   <= lcol;
        src.load_pixel <= lpix;
        src.out_row    <= orow;
        src.out_col    <= ocol;
        do
        begin
            @(negedge clk);
            took = src.ready;
            @(posedge clk);
        end
        while (!took);
        beats_sent++;
    endtask

    task automatic send_load(input int row, input int col, input logic [PIXEL_W-1:0] pix);
        send_beat(FUNC_LOAD, LOAD_IDX_W'(row), LOAD_IDX_W'(col), pix,
                  COORD_W'($urandom_range(COORD_MAX)), COORD_W'($urandom_range(COORD_MAX)));
        loaded[row][col] = 1'b1;
    endtask

    // load any neighbour not yet written, then query
    task automatic send_query(input int orow, input int ocol);
        int r0;
        int c0;
        int rr;
        int cc;
        r0 = source_index(orow, IMG_H);
        c0 = source_index(ocol, IMG_W);
        for (int i = 0; i < 4; i++)
        begin
            rr = (i[1] && r0 < IMG_H - 1) ? r0 + 1 : r0;
            cc = (i[0] && c0 < IMG_W - 1) ? c0 + 1 : c0;
            if (!loaded[rr][cc])
                send_load(rr, cc, pick_pixel());
        end
        send_beat(FUNC_QUERY, LOAD_IDX_W'($urandom_range(255)), LOAD_IDX_W'($urandom_range(255)),
                  PIXEL_W'($urandom_range(255)), COORD_W'(orow), COORD_W'(ocol));
    endtask

    task automatic settle();
        src.valid <= 1'b0;
        do
            @(posedge clk);
        while (pixels_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [INV_SCALE_W-1:0] value);
        logic took;
        settle();
        cfg.valid     <= 1'b1;
        cfg.inv_scale <= value;
        do
        begin
            @(negedge clk);
            took = cfg.ready;
            @(posedge clk);
        end
        while (!took);
        cfg.valid <= 1'b0;
        scale = value;
    endtask

    task automatic run_phase(input int count);
        int reach;
        int stop;
        reach = (scale == 0) ? COORD_MAX : (IMG_H << FRAC_BITS_DEF) / scale + 1;
        if (reach > COORD_MAX)
            reach = COORD_MAX;
        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            if ($urandom_range(99) < 15)
                send_load($urandom_range(IMG_H - 1), $urandom_range(IMG_W - 1), pick_pixel());
            else
                send_query(pick_coord(reach), pick_coord(reach));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        calm           = 1'b0;
        scale          = INV_SCALE_RESET;
        beats_sent     = 0;
        src.valid      = 1'b0;
        src.func       = FUNC_LOAD;
        src.load_row   = '0;
        src.load_col   = '0;
        src.load_pixel = '0;
        src.out_row    = '0;
        src.out_col    = '0;
        cfg.valid      = 1'b0;
        cfg.inv_scale  = INV_SCALE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_load(0, 0, 8'd255);
        send_load(0, 1, 8'd0);
        send_load(1, 0, 8'd0);
        send_load(1, 1, 8'd255);
        send_load(IMG_H - 1, IMG_W - 1, 8'd255);
        send_load(IMG_H - 1, IMG_W - 2, 8'd0);
        send_load(IMG_H - 2, IMG_W - 1, 8'd0);
        send_load(IMG_H - 2, IMG_W - 2, 8'd128);
        send_query(0, 0);
        send_query(IMG_H - 1, IMG_W - 1);
        send_query(COORD_MAX, COORD_MAX);
        send_query(0, COORD_MAX);
        send_query(COORD_MAX, 0);

        // half-pixel steps: fractions and saturation with a fraction left over
        write_scale(15'd2048);
        send_query(1, 1);
        send_query(1, 0);
        send_query(2 * IMG_H - 1, 2 * IMG_W - 1);
        send_query(COORD_MAX, 1);

        write_scale('0);
        run_phase(PHASE_BEATS);
        write_scale('1);
        run_phase(PHASE_BEATS);
        write_scale(15'd512);
        run_phase(PHASE_BEATS);
        write_scale(15'd16384);
        calm <= 1'b1;
        run_phase(PHASE_BEATS);
        calm <= 1'b0;
        write_scale(INV_SCALE_RESET);
        run_phase(PHASE_BEATS);
        write_scale(INV_SCALE_W'($urandom_range(16384, 512)));
        run_phase(PHASE_BEATS);
        write_scale(INV_SCALE_W'($urandom_range(32767)));
        run_phase(PHASE_BEATS);
        write_scale(INV_SCALE_W'($urandom_range(16384, 512)));
        run_phase(PHASE_BEATS);
        settle();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* bilinear_image_upscaler.f */
design/blu_pkg.sv
design/blu_if.sv
design/blu_pixel_store.sv
design/bilinear_image_upscaler.sv
dv/blu_pixel_checker.sv
dv/bilinear_image_upscaler_tb.sv
